### rtl/cpu_lma_pkg.sv
// cpu_lma_pkg: widths, constants and controller/datapath interface types
// for the processor-load moving average. No dependencies.
package cpu_lma_pkg;

  localparam int TICK_W       = 32;
  localparam int SUM_W        = 64;
  localparam int PERCENT_W    = 7;
  localparam int QUO_MSB      = 6;   // quotient below 128 needs seven steps
  localparam int REM_W        = SUM_W + PERCENT_W;
  localparam int DEFAULT_WINDOW_DEPTH = 8;

  localparam logic [PERCENT_W-1:0] PERCENT_MAX = 7'd100;

  // controller -> datapath
  typedef struct packed {
    logic accum;       // add the transferred counters into the running sums
    logic take_delta;  // form deltas, roll sums into previous, clear sums
    logic scale;       // pick a special-case entry or set up the divide
    logic div_step;    // one restoring divide step
    logic ring_write;  // store entry, update ring sum and pointers
    logic mean;        // multiply ring sum by the reciprocal of the depth
    logic load_out;    // move the mean into the output register
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic skip_div;    // entry decided without dividing
    logic div_last;    // current divide step is the final one
    logic out_free;    // output register can take a new result
  } dp_status_t;

endpackage

### rtl/cpu_lma_ram.sv
// cpu_lma_ram: generic single-write, single-read RAM with registered read.
// No dependencies.
module cpu_lma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/cpu_lma_ctrl.sv
// cpu_lma_ctrl: sequencing state machine for one sample close-out.
// Depends on cpu_lma_pkg.
module cpu_lma_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_last_i,
  output logic                    in_ready_o,
  output cpu_lma_pkg::dp_cmd_t    cmd_o,
  input  cpu_lma_pkg::dp_status_t status_i
);
  import cpu_lma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DELTA,
    ST_SCALE,
    ST_DIV,
    ST_WRITE,
    ST_MEAN,
    ST_LOAD
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    cmd_o            = '0;
    cmd_o.accum      = accept;
    cmd_o.take_delta = (state_q == ST_DELTA);
    cmd_o.scale      = (state_q == ST_SCALE);
    cmd_o.div_step   = (state_q == ST_DIV);
    cmd_o.ring_write = (state_q == ST_WRITE);
    cmd_o.mean       = (state_q == ST_MEAN);
    cmd_o.load_out   = (state_q == ST_LOAD) && status_i.out_free;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept && in_last_i) state_d = ST_DELTA;
      ST_DELTA: state_d = ST_SCALE;
      ST_SCALE: state_d = status_i.skip_div ? ST_WRITE : ST_DIV;
      ST_DIV:   if (status_i.div_last) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_MEAN;
      ST_MEAN:  state_d = ST_LOAD;
      ST_LOAD:  if (status_i.out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/cpu_lma_dp.sv
// cpu_lma_dp: sums, deltas, serial percent divide, ring of entries and
// mean, plus the output register. Depends on cpu_lma_pkg and cpu_lma_ram.
module cpu_lma_dp #(
  parameter int WINDOW_DEPTH = cpu_lma_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  cpu_lma_pkg::dp_cmd_t                   cmd_i,
  output cpu_lma_pkg::dp_status_t                status_o,
  input  logic [4*cpu_lma_pkg::TICK_W-1:0]       in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [cpu_lma_pkg::PERCENT_W-1:0]      out_percent_o,
  output logic                                   out_full_o
);
  import cpu_lma_pkg::*;

  localparam int IDX_W    = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int WARM_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int RSUM_W   = $clog2(100 * WINDOW_DEPTH + 1);
  // floor(x / depth) as (x * RECIP) >> SHIFT, exact for x < 2**RSUM_W
  localparam int SHIFT    = RSUM_W + $clog2(WINDOW_DEPTH) + 1;
  localparam int RECIP_W  = SHIFT + 1;
  localparam int PROD_W   = RSUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((1 << SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH);

  logic [SUM_W-1:0]     load_sum_q, total_sum_q, prev_load_q, prev_total_q;
  logic [SUM_W-1:0]     dload_q, dtotal_q;
  logic [REM_W-1:0]     rem_q, div_trial;
  logic [2:0]           step_q;
  logic [PERCENT_W-1:0] entry_q, old_entry, ram_rdata;
  logic [IDX_W-1:0]     idx_q;
  logic [WARM_W-1:0]    warm_q;
  logic [RSUM_W-1:0]    ring_sum_q;
  logic [PROD_W-1:0]    prod_q;
  logic                 full_now;
  logic                 div_fits;
  logic [TICK_W:0]      load_item;
  logic [TICK_W+1:0]    total_item;

  assign load_item  = {1'b0, in_data_i[0 +: TICK_W]} + {1'b0, in_data_i[TICK_W +: TICK_W]};
  assign total_item = {1'b0, load_item}
                    + {2'b0, in_data_i[2*TICK_W +: TICK_W]}
                    + {2'b0, in_data_i[3*TICK_W +: TICK_W]};

  assign full_now = (warm_q == WARM_W'(WINDOW_DEPTH));
  // a slot not yet written since reset reads as zero here, since the RAM has no reset
  assign old_entry = full_now ? ram_rdata : '0;

  assign div_trial = rem_q - ({{PERCENT_W{1'b0}}, dtotal_q} << step_q);
  assign div_fits  = (rem_q >= ({{PERCENT_W{1'b0}}, dtotal_q} << step_q));

  assign status_o.skip_div = (dtotal_q == '0) || (dload_q >= dtotal_q);
  assign status_o.div_last = (step_q == 3'd0);
  assign status_o.out_free = !out_valid_o || out_ready_i;

  cpu_lma_ram #(
    .WIDTH (PERCENT_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ring_write),
    .waddr_i (idx_q),
    .wdata_i (entry_q),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // control-side state: sums, pointers, fill count, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_sum_q   <= '0;
      total_sum_q  <= '0;
      prev_load_q  <= '0;
      prev_total_q <= '0;
      idx_q        <= '0;
      warm_q       <= '0;
      ring_sum_q   <= '0;
      out_valid_o  <= 1'b0;
    end else begin
      if (cmd_i.accum) begin
        load_sum_q  <= load_sum_q + SUM_W'(load_item);
        total_sum_q <= total_sum_q + SUM_W'(total_item);
      end else if (cmd_i.take_delta) begin
        prev_load_q  <= load_sum_q;
        prev_total_q <= total_sum_q;
        load_sum_q   <= '0;
        total_sum_q  <= '0;
      end
      if (cmd_i.ring_write) begin
        ring_sum_q <= ring_sum_q + RSUM_W'(entry_q) - RSUM_W'(old_entry);
        idx_q      <= (idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : idx_q + 1'b1;
        if (!full_now) warm_q <= warm_q + 1'b1;
      end
      if (cmd_i.load_out) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_delta) begin
      dload_q  <= load_sum_q - prev_load_q;
      dtotal_q <= total_sum_q - prev_total_q;
    end
    if (cmd_i.scale) begin
      if (dtotal_q == '0) begin
        entry_q <= (dload_q < SUM_W'(PERCENT_MAX)) ? dload_q[PERCENT_W-1:0] : PERCENT_MAX;
      end else if (dload_q >= dtotal_q) begin
        entry_q <= PERCENT_MAX;
      end else begin
        entry_q <= '0;
      end
      // 100 * dload = 64 + 32 + 4 times dload
      rem_q  <= ({{PERCENT_W{1'b0}}, dload_q} << 6)
              + ({{PERCENT_W{1'b0}}, dload_q} << 5)
              + ({{PERCENT_W{1'b0}}, dload_q} << 2);
      step_q <= 3'(QUO_MSB);
    end
    if (cmd_i.div_step) begin
      if (div_fits) begin
        rem_q           <= div_trial;
        entry_q[step_q] <= 1'b1;
      end
      step_q <= step_q - 1'b1;
    end
    if (cmd_i.mean) begin
      prod_q <= PROD_W'(ring_sum_q) * PROD_W'(RECIP);
    end
    if (cmd_i.load_out) begin
      out_percent_o <= full_now ? prod_q[SHIFT +: PERCENT_W] : '0;
      out_full_o    <= full_now;
    end
  end

endmodule

### rtl/cpu_load_moving_average.sv
// cpu_load_moving_average: top level of the smoothed processor-load block.
// Depends on cpu_lma_pkg, cpu_lma_ctrl, cpu_lma_dp and cpu_lma_ram.
//
// Usage: each slave-side transfer carries the cumulative tick counters of
// one processor; tlast marks the last processor of a sample. Per sample the
// block forms load (user + system) and total ticks, takes the deltas to the
// previous sample, computes the percent entry and pushes it into a ring of
// WINDOW_DEPTH entries. Each sample gives one master-side transfer: the
// truncated ring mean in tdata and, in tuser, a flag that the ring is full
// (the mean reads zero until WINDOW_DEPTH samples have been taken).
// Sequencing: a transfer without tlast leaves the slave side ready. After a
// transfer with tlast, tready stays low while the controller steps through
// delta, scale, the seven-step restoring divider for 100*dload/dtotal (skipped
// when the entry is decided without it), ring write, mean and load. The
// result becomes valid in the same cycle that the slave side reopens.
// The output register lets the next sample accumulate while a result waits;
// a stalled receiver only holds the next closing transfer in its last step.
// Reset clears the sums, previous sums, ring pointer, fill count, ring sum and output valid.
module cpu_load_moving_average #(
  parameter int WINDOW_DEPTH = cpu_lma_pkg::DEFAULT_WINDOW_DEPTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // user_ticks, system_ticks, idle_ticks, nice_ticks from bit 0 up:
  // user_ticks [31:0], system_ticks [63:32], idle_ticks [95:64],
  // nice_ticks [127:96]
  input  logic [4*cpu_lma_pkg::TICK_W-1:0]  s_axis_tdata,
  input  logic                              s_axis_tlast,   // last_cpu
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // load_percent [6:0], bit 7 zero
  output logic [7:0]                        m_axis_tdata,
  // window_full [0]
  output logic [0:0]                        m_axis_tuser
);
  import cpu_lma_pkg::*;

  dp_cmd_t              cmd;
  dp_status_t           status;
  logic [PERCENT_W-1:0] percent;
  logic                 full;

  cpu_lma_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_last_i  (s_axis_tlast),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  cpu_lma_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_data_i     (s_axis_tdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_percent_o (percent),
    .out_full_o    (full)
  );

  assign m_axis_tdata = {1'b0, percent};
  assign m_axis_tuser = full;

endmodule

### verif/cpu_load_moving_average_tb.sv
// cpu_load_moving_average_tb: self-checking bench for the smoothed processor-load block.
// A scoreboard class predicts each sample's ring mean; a task and a process drive the stream sides.
// Depends on cpu_lma_pkg and cpu_load_moving_average.
module cpu_load_moving_average_tb;
  import cpu_lma_pkg::*;

  localparam int CLK_PERIOD       = 12;
  localparam int RESET_CYCLES     = 8;
  localparam int RING_DEPTH       = DEFAULT_WINDOW_DEPTH;
  localparam int ITEM_TARGET      = 1800;
  localparam int LONG_HOLD_CYCLES = 400;   // receiver hold-off that backs up the block
  localparam int DRAIN_CYCLES     = 40;    // well past the closing latency
  localparam int TIMEOUT_CYCLES   = 1000000;
  localparam int MAX_CPUS         = 8;

  typedef logic [TICK_W-1:0] tick_t;

  // One predicted master-side transfer.
  typedef struct packed {
    logic [PERCENT_W-1:0] load_percent;
    logic                 window_full;
  } mean_result_t;

  // Predicts the load mean per sample and checks the results in order.
  class load_avg_scoreboard;
    logic [SUM_W-1:0]     load_acc, total_acc, prev_load, prev_total;
    logic [PERCENT_W-1:0] ring [RING_DEPTH];
    int unsigned          ring_pos, samples_seen;
    mean_result_t         expected_means [$];
    int unsigned          transfers, samples, results_seen, saturated, flat_total, errors;

    function new();
      load_acc     = '0;
      total_acc    = '0;
      prev_load    = '0;
      prev_total   = '0;
      ring_pos     = 0;
      samples_seen = 0;
      transfers    = 0;
      samples      = 0;
      results_seen = 0;
      saturated    = 0;
      flat_total   = 0;
      errors       = 0;
      foreach (ring[k]) ring[k] = '0;
    endfunction

    function int unsigned pending();
      return expected_means.size();
    endfunction

    // Percent entry of one sample from its load and total deltas.
    function logic [PERCENT_W-1:0] entry_percent(logic [SUM_W-1:0] dload,
                                                 logic [SUM_W-1:0] dtotal);
      logic [2*SUM_W-1:0] product;
      logic [2*SUM_W-1:0] quotient;
      if (dtotal == '0) begin
        flat_total++;
        return (dload >= SUM_W'(PERCENT_MAX)) ? PERCENT_MAX : dload[PERCENT_W-1:0];
      end
      if (dload >= dtotal) return PERCENT_MAX;
      // exact at 128 bits, so a huge wrapped load delta cannot overflow
      product  = (2*SUM_W)'(dload) * (2*SUM_W)'(100);
      quotient = product / (2*SUM_W)'(dtotal);
      return quotient[PERCENT_W-1:0];
    endfunction

    function void note_transfer(logic [4*TICK_W-1:0] data, logic last);
      tick_t                user, sys, idle, nice;
      logic [SUM_W-1:0]     dload, dtotal;
      logic [PERCENT_W-1:0] entry;
      int unsigned          ring_total;
      mean_result_t         want;
      user = data[TICK_W-1:0];
      sys  = data[2*TICK_W-1:TICK_W];
      idle = data[3*TICK_W-1:2*TICK_W];
      nice = data[4*TICK_W-1:3*TICK_W];
      transfers++;
      load_acc  += SUM_W'(user) + SUM_W'(sys);
      total_acc += SUM_W'(user) + SUM_W'(sys) + SUM_W'(idle) + SUM_W'(nice);
      if (!last) return;

      samples++;
      if (samples_seen < RING_DEPTH) samples_seen++;
      dload  = load_acc - prev_load;     // both deltas wrap modulo 2^64
      dtotal = total_acc - prev_total;
      entry  = entry_percent(dload, dtotal);
      if (entry == PERCENT_MAX) saturated++;
      ring[ring_pos] = entry;
      ring_pos   = (ring_pos + 1) % RING_DEPTH;
      prev_load  = load_acc;
      prev_total = total_acc;
      load_acc   = '0;
      total_acc  = '0;

      ring_total = 0;
      want.window_full = (samples_seen == RING_DEPTH);
      if (want.window_full) begin
        foreach (ring[k]) ring_total += ring[k];
      end
      want.load_percent = PERCENT_W'(ring_total / RING_DEPTH);
      expected_means.push_back(want);
    endfunction

    function void note_error(string field, logic [7:0] want, logic [7:0] got);
      errors++;
      if (errors <= 10)
        $display("ERROR result %0d: %s expected %0d, got %0d", results_seen, field, want, got);
    endfunction

    function void check_result(logic [7:0] data, logic full);
      mean_result_t want;
      results_seen++;
      if (expected_means.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR result %0d arrived with none pending: load %0d, full %0b",
                   results_seen, data[PERCENT_W-1:0], full);
        return;
      end
      want = expected_means.pop_front();
      if (data[PERCENT_W-1:0] !== want.load_percent)
        note_error("load_percent", 8'(want.load_percent), 8'(data[PERCENT_W-1:0]));
      if (full !== want.window_full)
        note_error("window_full", 8'(want.window_full), 8'(full));
      if (data[7] !== 1'b0)
        note_error("tdata pad bit", 8'd0, 8'(data[7]));
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [4*TICK_W-1:0]   s_axis_tdata;   // user [31:0], system [63:32], idle [95:64], nice [127:96]
  logic                  s_axis_tlast;   // last_cpu
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [7:0]            m_axis_tdata;   // load_percent [6:0], bit 7 zero
  logic [0:0]            m_axis_tuser;   // window_full [0]

  load_avg_scoreboard    sb;
  bit                    hold_req;      // asks the receiver for one long hold-off
  bit                    no_idle;       // both sides run without gaps while set
  int unsigned           items_sent;

  cpu_load_moving_average #(
    .WINDOW_DEPTH(RING_DEPTH)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Inputs only change at rising edges, so the falling edge sees the values
  // that the next rising edge will act on; both handshakes are judged there.
  always @(negedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser[0]);
  end

  // Receiver: random stalls, one long hold-off on request.
  initial begin : receiver
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
      end else begin
        stall = no_idle ? 0 : idle_gap();
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat (no_idle ? 1 : $urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  end

  // One slave-side transfer: optional gap, then hold the item until taken.
  task automatic send_cpu(input tick_t user, input tick_t sys, input tick_t idle,
                          input tick_t nice, input logic last);
    int gap;
    gap = no_idle ? 0 : idle_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {nice, idle, sys, user};
    s_axis_tlast  <= last;
    do @(negedge clk_i); while (!s_axis_tready);
    sb.note_transfer({nice, idle, sys, user}, last);
    @(posedge clk_i);
    items_sent++;
  endtask

  // Drop valid and wait until every predicted result has come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  initial begin : stimulus
    tick_t       cum_u [MAX_CPUS];
    tick_t       cum_s [MAX_CPUS];
    tick_t       cum_i [MAX_CPUS];
    tick_t       cum_n [MAX_CPUS];
    int          ncpu, kind;
    bit          hold_issued, pause_done;

    sb          = new();
    hold_req    = 1'b0;
    no_idle     = 1'b0;
    items_sent  = 0;
    hold_issued = 1'b0;
    pause_done  = 1'b0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed samples ----
    // first sample after reset: previous sums are zero, nothing elapsed
    send_cpu('0, '0, '0, '0, 1'b1);
    // every counter at its maximum: load is half the total
    send_cpu('1, '1, '1, '1, 1'b1);
    // identical sample: both deltas zero
    send_cpu('1, '1, '1, '1, 1'b1);
    // counters fall back: both deltas wrap, load delta not below total delta
    send_cpu('0, '0, 32'd50, '0, 1'b1);
    // load rises while total stays put: zero total delta, small load delta
    send_cpu(32'd50, '0, '0, '0, 1'b1);
    send_cpu('0, '0, '0, 32'd200, 1'b1);
    // zero total delta with a load delta past 100: saturates
    send_cpu('0, 32'd200, '0, '0, 1'b1);
    // load and total fall alike, then load falls by more: huge deltas, product needs 71 bits
    send_cpu(32'd100, '0, '0, '0, 1'b1);
    send_cpu('0, '0, 32'd50, '0, 1'b1);
    // four processors per sample, alternating bit patterns
    send_cpu(32'hAAAAAAAA, 32'h55555555, 32'h0F0F0F0F, 32'hF0F0F0F0, 1'b0);
    send_cpu(32'h55555555, 32'hAAAAAAAA, 32'hF0F0F0F0, 32'h0F0F0F0F, 1'b0);
    send_cpu(32'h80000000, 32'h00000001, 32'h7FFFFFFF, 32'hFFFFFFFE, 1'b0);
    send_cpu(32'h00000001, 32'h80000000, 32'hFFFFFFFE, 32'h7FFFFFFF, 1'b1);
    // same processors a little later: partial load
    send_cpu(32'hAAAAAB00, 32'h55555600, 32'h0F0F1000, 32'hF0F0F0F8, 1'b0);
    send_cpu(32'h55555600, 32'hAAAAAB00, 32'hF0F0F400, 32'h0F0F0F10, 1'b0);
    send_cpu(32'h80000080, 32'h00000041, 32'h7FFFFFFF, 32'hFFFFFFFE, 1'b0);
    send_cpu(32'h00000101, 32'h80000000, 32'hFFFFFFFE, 32'h7FFFFFFF, 1'b1);
    // two processors, all busy: in the second such sample, load delta equals total delta
    send_cpu(32'd1000, 32'd500, '0, '0, 1'b0);
    send_cpu(32'd2000, 32'd100, '0, '0, 1'b1);
    send_cpu(32'd1400, 32'd900, '0, '0, 1'b0);
    send_cpu(32'd2300, 32'd300, '0, '0, 1'b1);
    wait_drained();

    // ---- random samples ----
    foreach (cum_u[c]) begin
      cum_u[c] = $urandom;
      cum_s[c] = $urandom;
      cum_i[c] = $urandom;
      cum_n[c] = $urandom;
    end
    while (items_sent < ITEM_TARGET) begin
      // long receiver hold-off while the sender keeps offering
      if (!hold_issued && items_sent >= 500) begin
        hold_issued = 1'b1;
        hold_req    = 1'b1;
      end
      // sender pause until everything has come out
      if (!pause_done && items_sent >= 1000) begin
        pause_done = 1'b1;
        wait_drained();
      end
      no_idle = (items_sent >= 1250 && items_sent < 1450);

      ncpu = ($urandom_range(0, 9) == 0) ? $urandom_range(5, MAX_CPUS) : $urandom_range(1, 4);
      kind = $urandom_range(0, 99);
      for (int c = 0; c < ncpu; c++) begin
        if (kind < 72) begin
          // well-formed: cumulative counters advance by plausible tick counts,
          // wrapping at 32 bits now and then; some samples fully busy
          cum_u[c] += $urandom_range(0, 400);
          cum_s[c] += $urandom_range(0, 150);
          cum_i[c] += (kind < 10) ? 0 : $urandom_range(0, 1600);
          cum_n[c] += (kind < 10) ? 0 : $urandom_range(0, 30);
          send_cpu(cum_u[c], cum_s[c], cum_i[c], cum_n[c], c == ncpu - 1);
        end else if (kind < 80) begin
          // nothing elapsed since the last sample
          send_cpu(cum_u[c], cum_s[c], cum_i[c], cum_n[c], c == ncpu - 1);
        end else if (kind < 92) begin
          send_cpu($urandom, $urandom, $urandom, $urandom, c == ncpu - 1);
        end else begin
          // broken sample: closing flag lands anywhere
          send_cpu($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 3) == 0);
        end
      end
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d transfers in %0d samples, %0d results checked.",
             sb.transfers, sb.samples, sb.results_seen);
    $display("Entries saturated at 100: %0d; samples with zero total delta: %0d.",
             sb.saturated, sb.flat_total);
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("ERROR timeout with %0d results still pending", sb.pending());
    $display("Mismatches found");
    $finish;
  end

endmodule
